// ----- src/sharpen_3x3_rgb_stream_macros.svh -----
// ----------------------------------------------------------------------------
// Sharpen filter assertion macros
// Shared concurrent assertion forms for the sharpen filter. Define
// NO_ASSERTIONS to compile them away.
// ----------------------------------------------------------------------------
`ifndef SHARPEN_3X3_RGB_STREAM_MACROS_SVH
`define SHARPEN_3X3_RGB_STREAM_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define SHP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SHP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SHP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SHP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- src/shp_pkg.sv -----
// ----------------------------------------------------------------------------
// Sharpen filter package
// Types, codes and fixed constants shared by the sharpen filter modules.
// ----------------------------------------------------------------------------
package shp_pkg;

  localparam int CH_W   = 8;
  localparam int NUM_CH = 3;
  localparam int NBR_N  = 8;
  localparam int ACC_W  = CH_W + 5;
  localparam int CFG_W  = 11;
  localparam int ROW_W  = 10;
  localparam int IDX_W  = 1;

  localparam logic [CFG_W-1:0] W_MIN   = 11'd3;
  localparam logic [CFG_W-1:0] H_MIN   = 11'd3;
  localparam logic [CFG_W-1:0] H_MAX   = 11'd1024;
  localparam logic [CFG_W-1:0] RESET_W = 11'd644;
  localparam logic [CFG_W-1:0] RESET_H = 11'd410;

  typedef enum logic [IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_t;

  // Channel 2 is red, 1 is green, 0 is blue.
  typedef logic [NUM_CH-1:0][CH_W-1:0] pixel_t;

  typedef struct packed {
    pixel_t pix;
    logic   done;
  } result_t;

  function automatic logic [CFG_W-1:0] clamp_height(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] res;
    res = v;
    if (v < H_MIN) begin
      res = H_MIN;
    end else if (v > H_MAX) begin
      res = H_MAX;
    end
    return res;
  endfunction

endpackage

// ----- src/shp_in_if.sv -----
// ----------------------------------------------------------------------------
// Sharpen filter input channel
// Valid/ready channel carrying a command and one RGB pixel.
// ----------------------------------------------------------------------------
interface shp_in_if;
  import shp_pkg::*;

  logic            valid;
  logic            ready;
  logic            command;
  logic [CH_W-1:0] red_in;
  logic [CH_W-1:0] green_in;
  logic [CH_W-1:0] blue_in;

  modport source (output valid, output command, output red_in, output green_in,
                  output blue_in, input ready);
  modport sink   (input valid, input command, input red_in, input green_in,
                  input blue_in, output ready);
endinterface

// ----- src/shp_out_if.sv -----
// ----------------------------------------------------------------------------
// Sharpen filter result channel
// Valid/ready channel carrying one filtered RGB pixel and the end-of-frame flag.
// ----------------------------------------------------------------------------
interface shp_out_if;
  import shp_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_out;
  logic [CH_W-1:0] green_out;
  logic [CH_W-1:0] blue_out;
  logic            frame_done;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output frame_done, input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  input frame_done, output ready);
endinterface

// ----- src/shp_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Sharpen filter configuration channel
// Valid/ready register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface shp_cfg_if;
  import shp_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [CFG_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/shp_linemem.sv -----
// ----------------------------------------------------------------------------
// Sharpen filter line memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module shp_linemem #(
  parameter int DEPTH = 1024,
  parameter int DW    = 24
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);
  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  // Read-first: a same-cycle write is not seen by this read.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ----- src/shp_lane.sv -----
// ----------------------------------------------------------------------------
// Sharpen filter channel lane
// Nine times the center minus the eight neighbors, clamped to 0..255; the center passes through when sharpen is low.
// ----------------------------------------------------------------------------
module shp_lane (
  input  logic [shp_pkg::CH_W-1:0]                     center,
  input  logic [shp_pkg::NBR_N-1:0][shp_pkg::CH_W-1:0] nbr,
  input  logic                                         sharpen,
  output logic [shp_pkg::CH_W-1:0]                     result
);
  import shp_pkg::*;

  logic        [CH_W+2:0]  nbr_sum;
  logic        [ACC_W-1:0] center_x9;
  logic signed [ACC_W-1:0] acc;

  always_comb begin
    nbr_sum = '0;
    for (int k = 0; k < NBR_N; k++) begin
      nbr_sum = nbr_sum + {3'b000, nbr[k]};
    end
  end

  assign center_x9 = {2'b00, center, 3'b000} + {5'b00000, center};
  assign acc       = $signed(center_x9) - $signed({2'b00, nbr_sum});

  always_comb begin
    if (!sharpen) begin
      result = center;
    end else if (acc < 0) begin
      result = '0;
    end else if (acc > $signed(ACC_W'(255))) begin
      result = '1;
    end else begin
      result = acc[CH_W-1:0];
    end
  end
endmodule

// ----- src/shp_ostage.sv -----
// ----------------------------------------------------------------------------
// Sharpen filter output stage
// Holds each pushed result in an output register backed by a skid register.
// ----------------------------------------------------------------------------
module shp_ostage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  shp_pkg::result_t res,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output shp_pkg::result_t out_res
);
  import shp_pkg::*;

  result_t main_r;
  result_t skid_r;
  logic    main_vld_r;
  logic    skid_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!main_vld_r || out_ready) begin
      main_vld_r <= skid_vld_r || push;
      main_r     <= skid_vld_r ? skid_r : res;
      skid_vld_r <= 1'b0;
    end else if (push) begin
      skid_vld_r <= 1'b1;
      skid_r     <= res;
    end
  end

  assign in_ready  = rst_n && !skid_vld_r;
  assign out_valid = main_vld_r;
  assign out_res   = main_r;
endmodule

// ----- src/sharpen_3x3_rgb_stream.sv -----
// A pixel's result is registered in the output stage when the request that
// completes its neighborhood is taken, i.e. W+1 requests after the pixel itself
// in raster order. Throughput: one request per clock while the skid register of
// the output stage is empty; the three lanes are combinational.
// Reset (synchronous, active low) clears counters, window and output stage;
// line memory contents stay undefined until written.
// ----------------------------------------------------------------------------
// 3x3 sharpen filter for an RGB pixel stream
// Raster-order Laplacian sharpen with two line memories, a 3x3 window, one
// lane per color channel and a skid-buffered output stage.
// ----------------------------------------------------------------------------
`include "sharpen_3x3_rgb_stream_macros.svh"

module sharpen_3x3_rgb_stream #(
  parameter int MAX_LINE_PIXELS = 1024
) (
  input logic         clk,
  input logic         rst_n,
  shp_in_if.sink      in_chan,
  shp_out_if.source   out_chan,
  shp_cfg_if.sink     cfg_chan
);
  import shp_pkg::*;

  // Column index width, width-compare width and flush counter width.
  localparam int CW = $clog2(MAX_LINE_PIXELS);
  localparam int WW = ($clog2(MAX_LINE_PIXELS + 1) > CFG_W) ?
                      $clog2(MAX_LINE_PIXELS + 1) : CFG_W;
  localparam int PW = $clog2(MAX_LINE_PIXELS + 2);
  localparam int PXW = NUM_CH * CH_W;

  // The width register is kept already clamped to 3..MAX_LINE_PIXELS, so
  // every use below sees the value the filter really runs at.
  function automatic logic [WW-1:0] clamp_width(input logic [CFG_W-1:0] v);
    logic [WW-1:0] res;
    res = WW'(v);
    if (v < W_MIN) begin
      res = WW'(W_MIN);
    end else if (WW'(v) > WW'(MAX_LINE_PIXELS)) begin
      res = WW'(MAX_LINE_PIXELS);
    end
    return res;
  endfunction

  logic [WW-1:0]    frame_width_r;
  logic [CFG_W-1:0] frame_height_r;
  logic [CW-1:0]    col_r,  col_nxt;
  logic [ROW_W-1:0] row_r,  row_nxt;
  logic [PW-1:0]    pending_r, pending_nxt;
  pixel_t           win_r [6];

  pixel_t  px;
  pixel_t  top_rd;
  pixel_t  mid_rd;
  pixel_t  res_pix;
  result_t res;
  result_t out_res;

  logic             in_ready;
  logic             accept;
  logic             is_flush;
  logic             do_flush;
  logic             do_pixel;
  logic             produce;
  logic             interior;
  logic [WW-1:0]    col_inc;
  logic             col_wrap;
  logic [CFG_W-1:0] row_inc;
  logic             row_wrap;

  // --------------------------------------------------------------------------
  // Configuration. Writes are always taken outside reset; the register file
  // must be only written while the stream is idle; the block does not enforce it.
  // --------------------------------------------------------------------------
  assign cfg_chan.ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= clamp_width(RESET_W);
      frame_height_r <= clamp_height(RESET_H);
    end else if (cfg_chan.valid) begin
      unique case (cfg_idx_t'(cfg_chan.index))
        CFG_FRAME_WIDTH:  frame_width_r  <= clamp_width(cfg_chan.data);
        CFG_FRAME_HEIGHT: frame_height_r <= clamp_height(cfg_chan.data);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Request decode. A pixel request that arrives while the tail of a frame is
  // still being flushed is taken and dropped, as is a flush request when
  // nothing is owed.
  // --------------------------------------------------------------------------
  assign px[2] = in_chan.red_in;
  assign px[1] = in_chan.green_in;
  assign px[0] = in_chan.blue_in;

  assign in_chan.ready = in_ready;
  assign accept   = in_chan.valid && in_ready;
  assign is_flush = (in_chan.command == CMD_FLUSH);
  assign do_flush = accept && is_flush && (pending_r != '0);
  assign do_pixel = accept && !is_flush && (pending_r == '0);

  assign col_inc  = WW'(col_r) + WW'(1);
  assign col_wrap = (col_inc >= frame_width_r);
  assign row_inc  = CFG_W'(row_r) + CFG_W'(1);
  assign row_wrap = (row_inc >= frame_height_r);

  // --------------------------------------------------------------------------
  // Position counters and the flush counter. The last pixel of a frame sends
  // the position back to the origin and arms W+1 flush results, which drain
  // the last row and the pixel before it.
  // --------------------------------------------------------------------------
  always_comb begin
    col_nxt     = col_r;
    row_nxt     = row_r;
    pending_nxt = pending_r;
    if (do_flush) begin
      pending_nxt = pending_r - PW'(1);
      col_nxt     = col_wrap ? '0 : col_inc[CW-1:0];
      if (pending_r == PW'(1)) begin
        col_nxt = '0;
      end
    end else if (do_pixel) begin
      col_nxt = col_wrap ? '0 : col_inc[CW-1:0];
      if (col_wrap) begin
        if (row_wrap) begin
          row_nxt     = '0;
          pending_nxt = PW'(frame_width_r) + PW'(1);
        end else begin
          row_nxt = row_inc[ROW_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      pending_r <= '0;
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      pending_r <= pending_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Line memories. The read address is the column the next request will work
  // on, so the registered read data lines up with that request. The write
  // always lands on the current column, which is never the column being read
  // in the same cycle.
  // --------------------------------------------------------------------------
  shp_linemem #(
    .DEPTH (MAX_LINE_PIXELS),
    .DW    (PXW)
  ) u_upper_mem (
    .clk   (clk),
    .wr_en (do_pixel),
    .waddr (col_r),
    .wdata (mid_rd),
    .raddr (col_nxt),
    .rdata (top_rd)
  );

  shp_linemem #(
    .DEPTH (MAX_LINE_PIXELS),
    .DW    (PXW)
  ) u_middle_mem (
    .clk   (clk),
    .wr_en (do_pixel),
    .waddr (col_r),
    .wdata (px),
    .raddr (col_nxt),
    .rdata (mid_rd)
  );

  // --------------------------------------------------------------------------
  // 3x3 window: entries 0..2 are the left column (top to bottom), entries 3..5
  // the center column. The right column comes straight from the memories and
  // the incoming pixel. Flush requests shift in black on the bottom row.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 6; k++) begin
        win_r[k] <= '0;
      end
    end else if (do_flush || do_pixel) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top_rd;
      win_r[4] <= mid_rd;
      win_r[5] <= do_pixel ? px : '0;
    end
  end

  // --------------------------------------------------------------------------
  // Result selection. Pixels produce once the window center has been filled,
  // and only interior pixels are sharpened; border pixels and every flush
  // result pass the window center through unchanged.
  // --------------------------------------------------------------------------
  assign interior = (col_r >= CW'(2)) && (WW'(col_r) < frame_width_r) &&
                    (row_r >= ROW_W'(2)) && (CFG_W'(row_r) < frame_height_r);

  assign produce = do_flush ||
                   (do_pixel && ((row_r >= ROW_W'(2)) ||
                                 ((row_r == ROW_W'(1)) && (col_r != '0))));

  // One lane per color channel.
  for (genvar k = 0; k < NUM_CH; k++) begin : g_lane
    shp_lane u_lane (
      .center  (win_r[4][k]),
      .nbr     ({px[k], mid_rd[k], top_rd[k], win_r[5][k],
                 win_r[3][k], win_r[2][k], win_r[1][k], win_r[0][k]}),
      .sharpen (do_pixel && interior),
      .result  (res_pix[k])
    );
  end

  assign res.pix  = res_pix;
  assign res.done = do_flush && (pending_r == PW'(1));

  // The output stage keeps taking requests while one finished result waits, until its skid register fills.
  shp_ostage u_ostage (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (produce),
    .res       (res),
    .in_ready  (in_ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_res   (out_res)
  );

  assign out_chan.red_out    = out_res.pix[2];
  assign out_chan.green_out  = out_res.pix[1];
  assign out_chan.blue_out   = out_res.pix[0];
  assign out_chan.frame_done = out_res.done;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `SHP_ASSERT_IMP(a_flush_at_origin_row, clk, rst_n, pending_r != '0, row_r == '0, "row counter left the first row while flushing")
  `SHP_ASSERT_NXT(a_last_flush_resets, clk, rst_n, do_flush && pending_r == PW'(1), pending_r == '0 && col_r == '0, "last flush did not return to the origin")
  `SHP_ASSERT_IMP(a_stall_needs_result, clk, rst_n, !in_chan.ready, out_chan.valid, "input stalled with no result waiting")

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// Sharpen filter stream testbench
// Streams RGB frames of many sizes through the 3x3 sharpen filter, predicts
// every output pixel with a behavioral copy of the line stores and window, and
// checks each result in order. Both handshake sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb;
  import shp_pkg::*;

  localparam int unsigned MAX_COLS      = 1024;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_ITEMS  = 760;
  localparam int unsigned CALM_TAIL     = 200;
  localparam int unsigned TALL_PIXELS   = 120;
  localparam longint     TIMEOUT_UNITS = 64'd8_000_000;

  // Pixel content styles used when building frames.
  typedef enum int {
    STYLE_NOISE,
    STYLE_SMOOTH,
    STYLE_HARSH,
    STYLE_DIRECTED
  } px_style_t;

  // One input request as the driver presents it.
  typedef struct packed {
    cmd_t   cmd;
    pixel_t px;
  } pixel_request_t;

  logic clk = 1'b0;
  logic rst_n;

  shp_in_if  in_bus();
  shp_out_if out_bus();
  shp_cfg_if cfg_bus();

  sharpen_3x3_rgb_stream uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_chan (cfg_bus)
  );

  // The clock runs at a period of 8 units.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Behavioral copy of the filter. The line stores hold the two previous rows,
  // the window holds the last two columns of the 3x3 neighborhood, and the
  // counters track the raster position of the next pixel.
  // --------------------------------------------------------------------------
  pixel_t           upper_row  [MAX_COLS];
  pixel_t           middle_row [MAX_COLS];
  pixel_t           win        [6];
  int unsigned      col_pos;
  int unsigned      row_pos;
  int unsigned      flush_owed;
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;

  // Output pixels that the filter still owes, oldest first.
  result_t predicted_pixels [$];

  // Requests built by the stimulus process and not yet presented.
  pixel_request_t pixel_requests [$];

  int unsigned n_queued;
  int unsigned n_accepted;
  int unsigned n_useful;
  int unsigned n_results;
  int unsigned n_frames;
  int unsigned n_cfg_writes;
  int unsigned n_errors;
  bit          no_idle;

  // Frame content and the position the stimulus process has reached.
  px_style_t   px_style;
  pixel_t      base_px;
  pixel_t      nbr_px;
  int unsigned gen_row;
  int unsigned gen_col;

  // A register value is used clamped to 3..hi.
  function automatic int unsigned usable(input logic [CFG_W-1:0] v, input int unsigned hi);
    if (v < W_MIN) begin
      return W_MIN;
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  task automatic shift_window(input pixel_t top, input pixel_t mid, input pixel_t bot);
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = top;
    win[4] = mid;
    win[5] = bot;
  endtask

  // Advances the behavioral filter by one accepted request and records the
  // output pixel it causes, if any.
  task automatic sharpen_predict(input pixel_request_t req);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    pixel_t      top;
    pixel_t      mid;
    pixel_t      ctr;
    pixel_t      res;
    logic [23:0] ring [8];
    int          acc;
    int          ch;
    int          k;
    result_t     ent;
    w   = usable(width_reg, MAX_COLS);
    h   = usable(height_reg, H_MAX);
    c   = col_pos % MAX_COLS;
    r   = row_pos;
    top = upper_row[c];
    mid = middle_row[c];
    ctr = win[4];
    if (req.cmd == CMD_FLUSH) begin
      // A flush with nothing owed is dropped without effect.
      if (flush_owed != 0) begin
        flush_owed = flush_owed - 1;
        ent.pix  = ctr;
        ent.done = (flush_owed == 0);
        predicted_pixels.push_back(ent);
        shift_window(top, mid, '0);
        col_pos = (c + 1 >= w || flush_owed == 0) ? 0 : c + 1;
      end
    end else if (flush_owed == 0) begin
      // The pixel given out sits one row and one column behind this one.
      if (r >= 2 || (r == 1 && c >= 1)) begin
        res = ctr;
        // Only interior pixels are sharpened; borders pass through.
        if (c >= 2 && c < w && r >= 2 && r < h) begin
          ring[0] = win[0];
          ring[1] = win[1];
          ring[2] = win[2];
          ring[3] = win[3];
          ring[4] = win[5];
          ring[5] = top;
          ring[6] = mid;
          ring[7] = req.px;
          for (ch = 0; ch < NUM_CH; ch++) begin
            acc = 9 * int'(ctr[ch]);
            for (k = 0; k < NBR_N; k++) begin
              acc = acc - int'(ring[k][8*ch +: 8]);
            end
            res[ch] = (acc < 0) ? 8'd0 : ((acc > 255) ? 8'd255 : acc[7:0]);
          end
        end
        ent.pix  = res;
        ent.done = 1'b0;
        predicted_pixels.push_back(ent);
      end
      shift_window(top, mid, req.px);
      upper_row[c]  = mid;
      middle_row[c] = req.px;
      if (c + 1 >= w) begin
        col_pos = 0;
        if (r + 1 >= h) begin
          row_pos    = 0;
          flush_owed = w + 1;
        end else begin
          row_pos = r + 1;
        end
      end else begin
        col_pos = c + 1;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Input driver. Each cycle it either holds a request that has not been taken
  // yet, idles for a random burst, or presents the next queued request. A
  // request is predicted at the edge where it is accepted.
  // --------------------------------------------------------------------------
  pixel_request_t cur_req;
  int unsigned    in_gap;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        sharpen_predict(cur_req);
        n_accepted++;
      end
      if (in_bus.valid && !in_bus.ready) begin
        // The request stays on the bus until the filter takes it.
      end else if (in_gap > 0) begin
        in_gap--;
        in_bus.valid <= 1'b0;
      end else if (pixel_requests.size() == 0) begin
        in_bus.valid <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        in_gap = $urandom_range(0, 7);
        in_bus.valid <= 1'b0;
      end else begin
        cur_req = pixel_requests.pop_front();
        in_bus.valid    <= 1'b1;
        in_bus.command  <= cur_req.cmd;
        in_bus.red_in   <= cur_req.px[2];
        in_bus.green_in <= cur_req.px[1];
        in_bus.blue_in  <= cur_req.px[0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor. It compares every accepted result against the oldest
  // predicted pixel and stalls the filter in random bursts of its own.
  // --------------------------------------------------------------------------
  result_t     seen_ent;
  int unsigned out_gap;

  task automatic check_field(input string label, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (predicted_pixels.size() == 0) begin
          n_errors++;
          $display("%0t: result with none expected, actual R=%0d G=%0d B=%0d done=%0b",
                   $time, out_bus.red_out, out_bus.green_out, out_bus.blue_out,
                   out_bus.frame_done);
        end else begin
          seen_ent = predicted_pixels.pop_front();
          n_results++;
          check_field("red", seen_ent.pix[2], out_bus.red_out);
          check_field("green", seen_ent.pix[1], out_bus.green_out);
          check_field("blue", seen_ent.pix[0], out_bus.blue_out);
          check_field("frame_done", {7'd0, seen_ent.done}, {7'd0, out_bus.frame_done});
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_bus.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(0, 7);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------

  // Builds one pixel in the current style. Smooth frames keep the sharpened
  // value mostly inside 0..255, harsh and noisy frames drive the clamps.
  function automatic pixel_t make_pixel();
    pixel_t p;
    int     v;
    int     ch;
    p = '0;
    case (px_style)
      STYLE_NOISE: begin
        p = pixel_t'($urandom);
      end
      STYLE_SMOOTH: begin
        for (ch = 0; ch < NUM_CH; ch++) begin
          v = int'(base_px[ch]) + int'($urandom_range(0, 40)) - 20;
          p[ch] = (v < 0) ? 8'd0 : ((v > 255) ? 8'd255 : v[7:0]);
        end
      end
      STYLE_HARSH: begin
        for (ch = 0; ch < NUM_CH; ch++) begin
          case ($urandom_range(0, 3))
            0: p[ch] = 8'd0;
            1: p[ch] = 8'd255;
            2: p[ch] = 8'($urandom_range(0, 7));
            default: p[ch] = 8'($urandom_range(248, 255));
          endcase
        end
      end
      default: begin
        // Hand-picked frames: one value at the only interior pixel, another
        // everywhere around it.
        p = (gen_row == 1 && gen_col == 1) ? base_px : nbr_px;
      end
    endcase
    return p;
  endfunction

  task automatic push_request(input cmd_t cmd, input pixel_t px, input bit counts);
    pixel_request_t req;
    req.cmd = cmd;
    req.px  = px;
    pixel_requests.push_back(req);
    n_queued++;
    if (counts) begin
      n_useful++;
    end
  endtask

  // Waits until every request has been taken and every result has come back,
  // then lets the pipeline settle, since a pixel request may cause no result.
  task automatic wait_idle();
    while (n_accepted != n_queued || predicted_pixels.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes happen only while the filter is idle.
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do begin
      @(posedge clk);
    end while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    case (idx)
      CFG_FRAME_WIDTH: width_reg = val;
      default:         height_reg = val;
    endcase
    n_cfg_writes++;
    @(posedge clk);
  endtask

  // Sends one pixel, optionally preceded by a flush the filter must ignore,
  // and reports whether it was the last pixel of the frame.
  task automatic send_pixel(input int unsigned noise, output bit ended);
    int unsigned w;
    int unsigned h;
    w = usable(width_reg, MAX_COLS);
    h = usable(height_reg, H_MAX);
    if (noise != 0 && $urandom_range(1, noise) == 1) begin
      push_request(CMD_FLUSH, pixel_t'($urandom), 1'b0);
    end
    push_request(CMD_PIXEL, make_pixel(), 1'b1);
    ended = 1'b0;
    if (gen_col + 1 >= w) begin
      gen_col = 0;
      if (gen_row + 1 >= h) begin
        gen_row = 0;
        ended   = 1'b1;
      end else begin
        gen_row++;
      end
    end else begin
      gen_col++;
    end
  endtask

  // Sends the rest of the current frame and the flush requests that drain the
  // last row. Pixels slipped in between flushes are ignored by the filter.
  task automatic finish_frame(input int unsigned noise);
    bit          ended;
    int unsigned owed;
    int unsigned i;
    ended = 1'b0;
    while (!ended) begin
      send_pixel(noise, ended);
    end
    owed = usable(width_reg, MAX_COLS) + 1;
    for (i = 0; i < owed; i++) begin
      push_request(CMD_FLUSH, pixel_t'($urandom), 1'b1);
      if (noise != 0 && i + 1 < owed && $urandom_range(1, noise) == 1) begin
        push_request(CMD_PIXEL, pixel_t'($urandom), 1'b0);
      end
    end
    if (noise != 0 && $urandom_range(1, noise) == 1) begin
      push_request(CMD_FLUSH, pixel_t'($urandom), 1'b0);
    end
    n_frames++;
  endtask

  function automatic logic [CFG_W-1:0] pick_width();
    case ($urandom_range(0, 9))
      0:       return CFG_W'($urandom_range(0, 2));
      1:       return CFG_W'($urandom_range(13, 40));
      default: return CFG_W'($urandom_range(3, 12));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_height();
    case ($urandom_range(0, 9))
      0:       return CFG_W'($urandom_range(0, 2));
      1:       return CFG_W'($urandom_range(7, 12));
      default: return CFG_W'($urandom_range(3, 6));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    bit          ended;
    int unsigned i;
    int unsigned cut;
    int unsigned random_start;

    in_bus.valid    = 1'b0;
    in_bus.command  = CMD_PIXEL;
    in_bus.red_in   = '0;
    in_bus.green_in = '0;
    in_bus.blue_in  = '0;
    out_bus.ready   = 1'b0;
    cfg_bus.valid   = 1'b0;
    cfg_bus.index   = CFG_FRAME_WIDTH;
    cfg_bus.data    = '0;
    foreach (upper_row[j]) begin
      upper_row[j]  = '0;
      middle_row[j] = '0;
    end
    foreach (win[j]) begin
      win[j] = '0;
    end
    col_pos    = 0;
    row_pos    = 0;
    flush_owed = 0;
    width_reg  = RESET_W;
    height_reg = RESET_H;
    gen_row    = 0;
    gen_col    = 0;
    px_style   = STYLE_SMOOTH;
    base_px    = pixel_t'($urandom);
    nbr_px     = '0;

    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Start at the reset size: the first result shows up only after one full
    // row plus one pixel, which pins down the reset width. The frame is then
    // cut to forty columns and three rows while still in progress, which also
    // leaves every line store entry that later frames can reach written.
    for (i = 0; i < RESET_W + 2; i++) begin
      send_pixel(0, ended);
    end
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, 11'd40);
    write_reg(CFG_FRAME_HEIGHT, 11'd3);
    finish_frame(0);

    // Hand-picked 3x3 frames. The first uses register values below the legal
    // range and ignored requests at every opportunity; its channels clamp high,
    // clamp low and clamp high again. The second lands inside 0..255.
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, 11'd0);
    write_reg(CFG_FRAME_HEIGHT, 11'd1);
    px_style = STYLE_DIRECTED;
    base_px  = {8'd255, 8'd0, 8'd128};
    nbr_px   = {8'd0, 8'd255, 8'd16};
    finish_frame(1);
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, 11'd3);
    write_reg(CFG_FRAME_HEIGHT, 11'd3);
    base_px = {8'd120, 8'd3, 8'd250};
    nbr_px  = {8'd130, 8'd1, 8'd255};
    finish_frame(0);

    // A height above the legal range runs forty narrow rows without wrapping,
    // then the height is cut back so the frame ends at the next line end.
    wait_idle();
    write_reg(CFG_FRAME_HEIGHT, 11'd2047);
    px_style = STYLE_SMOOTH;
    base_px  = pixel_t'($urandom);
    for (i = 0; i < TALL_PIXELS; i++) begin
      send_pixel(0, ended);
    end
    wait_idle();
    write_reg(CFG_FRAME_HEIGHT, 11'd3);
    finish_frame(0);

    // Random frames of small sizes. About one frame in four is resized while
    // it is still in progress. The tail of the run goes without idling.
    random_start = n_useful;
    while (n_useful - random_start < RANDOM_ITEMS) begin
      no_idle = (n_useful - random_start >= RANDOM_ITEMS - CALM_TAIL);
      wait_idle();
      write_reg(CFG_FRAME_WIDTH, pick_width());
      write_reg(CFG_FRAME_HEIGHT, pick_height());
      px_style = px_style_t'($urandom_range(0, 2));
      base_px  = pixel_t'($urandom);
      if ($urandom_range(0, 3) == 0) begin
        cut = $urandom_range(1, usable(width_reg, MAX_COLS) * usable(height_reg, H_MAX) - 1);
        for (i = 0; i < cut; i++) begin
          send_pixel(20, ended);
        end
        wait_idle();
        case ($urandom_range(0, 2))
          0: write_reg(CFG_FRAME_WIDTH, pick_width());
          1: write_reg(CFG_FRAME_HEIGHT, pick_height());
          default: begin
            write_reg(CFG_FRAME_WIDTH, pick_width());
            write_reg(CFG_FRAME_HEIGHT, pick_height());
          end
        endcase
      end
      finish_frame(20);
    end

    wait_idle();
    $display("Run covered %0d requests (%0d meant to be ignored) and %0d checked pixels in %0d frames.",
             n_queued, n_queued - n_useful, n_results, n_frames);
    $display("%0d register writes covered clamped sizes, the reset width, a tall frame and resizes.",
             n_cfg_writes);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Safety net in case the filter stops answering.
  initial begin
    #(TIMEOUT_UNITS);
    $display("%0t: timeout, %0d results still outstanding", $time, predicted_pixels.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
